FILE: rtl/core/cbam_pkg.sv
// Shared types and constants of the container block address map.
package cbam_pkg;

    localparam int IDX_BITS     = 24;
    localparam int LVL_BITS     = 2;
    localparam int PHYS_BITS    = 25;
    localparam int BYTE_BITS    = 37;
    localparam int BLOCK_SHIFT  = 12;
    localparam int HDR_BITS     = 32;
    localparam int CFG_IDX_BITS = 1;

    localparam int          TREE_LEVELS_DEF = 3;
    localparam int unsigned ENTRIES_DEF     = 170;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_TABLE = 1'b1;

    localparam logic [LVL_BITS-1:0] LEVEL_0 = 2'd0;
    localparam logic [LVL_BITS-1:0] LEVEL_1 = 2'd1;
    localparam logic [LVL_BITS-1:0] LEVEL_2 = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLES = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEADER = 1'b1;

    typedef struct packed {
        logic                func;
        logic [IDX_BITS-1:0] blk_num;
        logic [LVL_BITS-1:0] tree_level;
    } t_request;

    typedef struct packed {
        logic [PHYS_BITS-1:0] physical_block;
        logic [BYTE_BITS-1:0] byte_offset;
    } t_result;

endpackage

FILE: rtl/core/cbam_div.sv
// Three-stage divider by a constant: reciprocal multiply, back-multiply, one-step correction.
module cbam_div #(
    parameter int              IN_BITS = cbam_pkg::IDX_BITS,
    parameter longint unsigned DIVISOR = 64'(cbam_pkg::ENTRIES_DEF)
) (
    input  logic               i_clk,
    input  logic [IN_BITS-1:0] i_num,
    output logic [IN_BITS-1:0] o_quot
);

    // floor(2^IN_BITS / DIVISOR): the estimate is the true quotient or one below it
    localparam logic [IN_BITS-1:0] RECIP   = IN_BITS'((64'd1 << IN_BITS) / DIVISOR);
    localparam logic [IN_BITS-1:0] DIV_LOW = IN_BITS'(DIVISOR);

    logic [2*IN_BITS-1:0] n_prod;
    logic [IN_BITS-1:0]   r_num1;
    logic [IN_BITS-1:0]   r_qe1;
    logic [IN_BITS-1:0]   r_num2;
    logic [IN_BITS-1:0]   r_qe2;
    logic [IN_BITS-1:0]   r_pd2;
    logic [IN_BITS-1:0]   n_rem;
    logic                 n_ge;
    logic [IN_BITS-1:0]   r_quot;

    assign n_prod = (2*IN_BITS)'(i_num) * (2*IN_BITS)'(RECIP);

    // back-product never exceeds the numerator, so its low bits are exact
    assign n_rem = r_num2 - r_pd2;
    assign n_ge  = (64'(n_rem) >= DIVISOR);

    always_ff @(posedge i_clk) begin
        r_num1 <= i_num;
        r_qe1  <= n_prod[2*IN_BITS-1:IN_BITS];
        r_num2 <= r_num1;
        r_qe2  <= r_qe1;
        r_pd2  <= r_qe1 * DIV_LOW;
        r_quot <= r_qe2 + IN_BITS'(n_ge);
    end

    assign o_quot = r_quot;

endmodule

FILE: rtl/core/container_block_address_map_core.sv
// Top level of the container block address map: seven-stage lookup pipeline.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+-------------------------
//  request   | start, busy, i_request                         | taken when start & !busy
//  result    | o_strobe, o_result                             | one-cycle strobe, no stall
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | valid & ready
//
// One request per cycle; each request taken yields exactly one result strobe.
// The depth is set by the request register, the constant dividers (reciprocal
// multiply, back-multiply, correction) and the product, sum and byte-offset stages.
// busy stays low: the pipeline never holds, since the receiver cannot stall.
// Synchronous reset clears the valid bits and the configuration registers.
module container_block_address_map_core #(
    parameter int          TREE_LEVELS       = cbam_pkg::TREE_LEVELS_DEF,
    parameter int unsigned ENTRIES_PER_TABLE = cbam_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cbam_pkg::t_request                  i_request,
    output logic                                o_strobe,
    output cbam_pkg::t_result                   o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cbam_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [cbam_pkg::HDR_BITS-1:0]       i_cfg_data
);

    localparam int IB = cbam_pkg::IDX_BITS;
    localparam int PB = cbam_pkg::PHYS_BITS;
    localparam int BB = cbam_pkg::BYTE_BITS;
    localparam int LB = cbam_pkg::LVL_BITS;
    localparam int LATENCY = 7;
    localparam int HDR_BITS_W = cbam_pkg::HDR_BITS + 1;

    localparam longint unsigned SPAN0 = 64'(ENTRIES_PER_TABLE);
    localparam longint unsigned SPAN1 = SPAN0 * SPAN0;
    localparam longint unsigned SPAN2 = SPAN1 * SPAN0;

    localparam logic [PB-1:0] K_E    = PB'(SPAN0);
    localparam logic [PB-1:0] K_E2   = PB'(SPAN1);
    localparam logic [PB-1:0] K_E1   = PB'(SPAN0 + 64'd1);
    localparam logic [PB-1:0] STEP0A = PB'(SPAN0 + 64'd1);
    localparam logic [PB-1:0] STEP0B = PB'(SPAN0 + 64'd2);
    localparam logic [PB-1:0] STEP1A = PB'(SPAN1 + SPAN0 + 64'd1);
    localparam logic [PB-1:0] STEP1B = PB'(SPAN1 + 2 * (SPAN0 + 64'd1));

    localparam logic [LB-1:0] LVL_TOP =
        (TREE_LEVELS >= 3) ? cbam_pkg::LEVEL_2 : LB'(TREE_LEVELS - 1);

    typedef struct packed {
        logic          func;
        logic [LB-1:0] lvl;
        logic [IB-1:0] idx;
    } t_ctl;

    logic                  n_accept;
    logic [LB-1:0]         n_lvl;
    logic [3:0]            r_vld;
    t_ctl                  r_ctl [4];
    logic [IB-1:0]         q0;
    logic [IB-1:0]         q1;
    logic [IB-1:0]         q2;

    logic                  r_two;
    logic [BB-1:0]         r_base;
    logic [HDR_BITS_W-1:0] n_base;

    logic                  r_v5;
    t_ctl                  r_c5;
    logic [PB-1:0]         r_m0;
    logic [PB-1:0]         r_m1a;
    logic [PB-1:0]         r_m1b;
    logic [PB-1:0]         r_q0;
    logic [PB-1:0]         r_q1;
    logic [PB-1:0]         r_q2;
    logic                  r_nz0;
    logic                  r_nz1;

    logic [PB-1:0]         n_tk;
    logic [PB-1:0]         n_sum;
    logic [PB-1:0]         n_blk;
    logic                  r_v6;
    logic [PB-1:0]         r_blk;

    logic                  r_strobe;
    cbam_pkg::t_result     r_result;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = start && !busy;

    // clamp the level to the top of the tree
    assign n_lvl = (i_request.tree_level > LVL_TOP) ? LVL_TOP : i_request.tree_level;

    // header size rounded up to a whole block
    assign n_base = (HDR_BITS_W'(i_cfg_data) + HDR_BITS_W'(4095))
                    & ~HDR_BITS_W'(4095);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two  <= 1'b0;
            r_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cbam_pkg::CFG_TABLES: r_two  <= i_cfg_data[1];
                cbam_pkg::CFG_HEADER: r_base <= BB'(n_base);
                default: ;
            endcase
        end
    end

    // request register and control shift line alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], n_accept};
        end
        r_ctl[0] <= '{func: i_request.func, lvl: n_lvl, idx: i_request.blk_num};
        for (int s = 1; s < 4; s++) begin
            r_ctl[s] <= r_ctl[s-1];
        end
    end

    cbam_div #(.IN_BITS(IB), .DIVISOR(SPAN0)) u_div0 (
        .i_clk(i_clk), .i_num(r_ctl[0].idx), .o_quot(q0)
    );
    cbam_div #(.IN_BITS(IB), .DIVISOR(SPAN1)) u_div1 (
        .i_clk(i_clk), .i_num(r_ctl[0].idx), .o_quot(q1)
    );
    cbam_div #(.IN_BITS(IB), .DIVISOR(SPAN2)) u_div2 (
        .i_clk(i_clk), .i_num(r_ctl[0].idx), .o_quot(q2)
    );

    // products of the quotients; only the low physical bits are ever kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_vld[3];
        end
        r_c5  <= r_ctl[3];
        r_m0  <= PB'(q0) * K_E;
        r_m1a <= PB'(q1) * K_E2;
        r_m1b <= PB'(q1) * K_E1;
        r_q0  <= PB'(q0);
        r_q1  <= PB'(q1);
        r_q2  <= PB'(q2);
        r_nz0 <= (q0 != '0);
        r_nz1 <= (q1 != '0);
    end

    always_comb begin
        n_tk  = r_two ? PB'(2) : PB'(1);
        // data mode: count quotient-plus-one tables per level up to the first level that covers it
        n_sum = r_q0 + PB'(1);
        if (TREE_LEVELS >= 2 && r_nz0) begin
            n_sum = n_sum + r_q1 + PB'(1);
        end
        if (TREE_LEVELS >= 3 && r_nz1) begin
            n_sum = n_sum + r_q2 + PB'(1);
        end
        if (r_c5.func == cbam_pkg::FUNC_DATA) begin
            n_blk = PB'(r_c5.idx) + (n_sum << r_two);
        end else begin
            case (r_c5.lvl)
                cbam_pkg::LEVEL_0: begin
                    if (r_nz0) begin
                        n_blk = r_m0 + (r_q0 << r_two) + ((r_q1 + PB'(1)) << r_two)
                                + (r_nz1 ? n_tk : '0);
                    end else begin
                        n_blk = '0;
                    end
                end
                cbam_pkg::LEVEL_1: begin
                    if (r_nz1) begin
                        n_blk = r_m1a + (r_m1b << r_two) + n_tk;
                    end else begin
                        n_blk = r_two ? STEP0B : STEP0A;
                    end
                end
                default: n_blk = r_two ? STEP1B : STEP1A;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v6     <= r_v5;
            r_strobe <= r_v6;
        end
        r_blk                   <= n_blk;
        r_result.physical_block <= r_blk;
        r_result.byte_offset    <= r_base + (BB'(r_blk) << cbam_pkg::BLOCK_SHIFT);
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // every request taken yields exactly one strobe after the pipeline depth
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> ##LATENCY o_strobe)
        else $error("request without result");

    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(n_accept, LATENCY))
        else $error("result without request");

    // byte offset and physical block must agree under the header base
    a_offset_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (((o_result.byte_offset - r_base) >> cbam_pkg::BLOCK_SHIFT)
                      == BB'(o_result.physical_block)))
        else $error("byte offset disagrees with physical block");

endmodule

FILE: dv/tb_container_block_address_map_core.sv
// Self-checking testbench for the container block address map core.
`timescale 1ns / 1ps

module tb_container_block_address_map_core;
    import cbam_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 242;

    // Scoreboard: own copy of the registers and the queue of expected locations.
    class address_map_scoreboard;
        logic [1:0]  tables_cfg;
        logic [31:0] header_cfg;
        t_result     pending_results[$];
        int          fail_count;

        function new();
            tables_cfg = 2'd1;
            header_cfg = '0;
            fail_count = 0;
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= 100) begin
                $display("%0t ns mismatch: %s", $time, msg);
            end
        endtask

        function void apply_config(logic [CFG_IDX_BITS-1:0] index, logic [31:0] data);
            if (index == CFG_TABLES) begin
                tables_cfg = data[1:0];
            end else if (index == CFG_HEADER) begin
                header_cfg = data;
            end
        endfunction

        // Only bit 1 of the copy count matters: 0 acts as 1, 3 as 2.
        function logic [63:0] table_copies();
            return tables_cfg[1] ? 64'd2 : 64'd1;
        endfunction

        function logic [63:0] level_span(int lvl);
            logic [63:0] e;
            e = 64'(ENTRIES_DEF);
            if (lvl == 0) return e;
            if (lvl == 1) return e * e;
            return e * e * e;
        endfunction

        // Count in every table lying before the block; a block equal to a
        // level's coverage sees that level's table ahead of it.
        function logic [63:0] data_location(logic [63:0] idx);
            logic [63:0] t;
            logic [63:0] blk;
            logic [63:0] span;
            t   = table_copies();
            blk = idx;
            for (int lvl = 0; lvl < TREE_LEVELS_DEF && lvl < 3; lvl++) begin
                span = level_span(lvl);
                blk += ((idx + span) / span) * t;
                if (idx < span) break;
            end
            return blk;
        endfunction

        function logic [63:0] table_location(logic [63:0] idx, logic [LVL_BITS-1:0] lvl);
            logic [63:0] t;
            logic [63:0] s0;
            logic [63:0] s1;
            logic [63:0] step0;
            logic [63:0] step1;
            logic [63:0] blk;
            t     = table_copies();
            s0    = level_span(0);
            s1    = level_span(1);
            step0 = s0 + t;
            step1 = s1 + (s0 + 64'd1) * t;
            if (lvl >= LEVEL_2) return step1;
            if (lvl == LEVEL_1) begin
                if (idx < s1) return step0;
                return (idx / s1) * step1 + t;
            end
            if (idx < s0) return 64'd0;
            blk = (idx / s0) * step0 + (idx / s1 + 64'd1) * t;
            if (idx < s1) return blk;
            return blk + t;
        endfunction

        function void note_request(t_request req);
            logic [LVL_BITS-1:0] lvl;
            logic [LVL_BITS-1:0] top_level;
            logic [63:0]         blk;
            logic [63:0]         base;
            logic [63:0]         bytes;
            t_result             exp_res;
            top_level = (TREE_LEVELS_DEF >= 3) ? LEVEL_2 : LVL_BITS'(TREE_LEVELS_DEF - 1);
            lvl = req.tree_level;
            if (lvl > top_level) lvl = top_level;
            blk = (req.func == FUNC_TABLE) ? table_location(64'(req.blk_num), lvl)
                                           : data_location(64'(req.blk_num));
            base  = (64'(header_cfg) + 64'd4095) & ~64'd4095;
            // Byte offset uses the block masked to its low 25 bits, then wraps to its own width.
            bytes = base + ((blk & ((64'd1 << (BYTE_BITS - BLOCK_SHIFT)) - 64'd1))
                            << BLOCK_SHIFT);
            exp_res.physical_block = blk[PHYS_BITS-1:0];
            exp_res.byte_offset    = bytes[BYTE_BITS-1:0];
            pending_results = {pending_results, exp_res};
        endfunction

        task check_result(t_result got);
            t_result exp_res;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h with no request outstanding", got));
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.physical_block !== exp_res.physical_block) begin
                report($sformatf("physical_block got %h exp %h",
                                 got.physical_block, exp_res.physical_block));
            end
            if (got.byte_offset !== exp_res.byte_offset) begin
                report($sformatf("byte_offset got %h exp %h",
                                 got.byte_offset, exp_res.byte_offset));
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    t_request                i_request;
    logic                    o_strobe;
    t_result                 o_result;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [HDR_BITS-1:0]     i_cfg_data;

    address_map_scoreboard sb;
    int                    stall_cycles = 0;

    container_block_address_map_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_request   (i_request),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Sample every handshake at the rising edge; check results before noting
    // the request taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_result);
            if (start && !busy) sb.note_request(i_request);
            if (i_cfg_valid && o_cfg_ready) sb.apply_config(i_cfg_index, i_cfg_data);
            if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_container_block_address_map_core: FAIL");
                $finish;
            end
        end
    end

    function automatic t_request make_request(logic func, int unsigned idx,
                                              logic [LVL_BITS-1:0] lvl);
        t_request r;
        r.func       = func;
        r.blk_num    = idx[IDX_BITS-1:0];
        r.tree_level = lvl;
        return r;
    endfunction

    // Blocks near level boundaries, small indexes and fully random indexes.
    function automatic t_request random_request();
        t_request    r;
        int unsigned span;
        int unsigned k;
        int unsigned v;
        int unsigned pick;
        r.func       = 1'($urandom_range(1));
        r.tree_level = LVL_BITS'($urandom_range(3));
        pick = $urandom_range(9);
        if (pick < 4) begin
            case ($urandom_range(2))
                0: begin
                    span = ENTRIES_DEF;
                end
                1: begin
                    span = ENTRIES_DEF * ENTRIES_DEF;
                end
                default: begin
                    span = ENTRIES_DEF * ENTRIES_DEF * ENTRIES_DEF;
                end
            endcase
            k = $urandom_range(1, 32'hFF_FFFF / span);
            v = k * span + $urandom_range(4) - 2;
            r.blk_num = v[IDX_BITS-1:0];
        end else if (pick < 6) begin
            r.blk_num = IDX_BITS'($urandom_range(400));
        end else begin
            r.blk_num = IDX_BITS'($urandom());
        end
        return r;
    endfunction

    task automatic send_request(t_request req, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start     = 1'b1;
        i_request = req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] index, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop start and let the pipeline empty before touching the registers.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_request    directed[$];
        logic [1:0]  phase_tables[PHASE_COUNT];
        logic [31:0] phase_header[PHASE_COUNT];
        int          phase_idle[PHASE_COUNT];

        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_request   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TABLES;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Level boundaries, index extremes and level saturation under reset values.
        directed = '{
            make_request(FUNC_DATA, 0, LEVEL_0),
            make_request(FUNC_DATA, 1, LEVEL_2),
            make_request(FUNC_DATA, 169, LEVEL_0),
            make_request(FUNC_DATA, 170, LEVEL_1),
            make_request(FUNC_DATA, 171, LEVEL_0),
            make_request(FUNC_DATA, 340, 2'd3),
            make_request(FUNC_DATA, 28899, LEVEL_0),
            make_request(FUNC_DATA, 28900, LEVEL_0),
            make_request(FUNC_DATA, 28901, LEVEL_0),
            make_request(FUNC_DATA, 4912999, LEVEL_0),
            make_request(FUNC_DATA, 4913000, LEVEL_0),
            make_request(FUNC_DATA, 4913001, LEVEL_0),
            make_request(FUNC_DATA, 16777215, 2'd3),
            make_request(FUNC_TABLE, 0, LEVEL_0),
            make_request(FUNC_TABLE, 169, LEVEL_0),
            make_request(FUNC_TABLE, 170, LEVEL_0),
            make_request(FUNC_TABLE, 57800, LEVEL_0),
            make_request(FUNC_TABLE, 28899, LEVEL_1),
            make_request(FUNC_TABLE, 28900, LEVEL_1),
            make_request(FUNC_TABLE, 4913000, LEVEL_2),
            make_request(FUNC_TABLE, 16777215, LEVEL_0),
            make_request(FUNC_TABLE, 16777215, LEVEL_1),
            make_request(FUNC_TABLE, 170, 2'd3)
        };
        foreach (directed[i]) send_request(directed[i], 0);

        phase_tables = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};
        phase_header = '{32'd0, 32'hFFFF_FFFF, 32'd4096, 32'd4097, 32'd1, $urandom()};
        phase_idle   = '{0, 79, 29, 0, 79, 29};
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            write_register(CFG_TABLES, ($urandom() & 32'hFFFF_FFFC) | 32'(phase_tables[p]));
            write_register(CFG_HEADER, phase_header[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(random_request(), phase_idle[p]);
            end
        end
        drain();

        if (sb.pending_results.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
        end
        if (sb.fail_count == 0) begin
            $display("tb_container_block_address_map_core: PASS");
        end else begin
            $display("tb_container_block_address_map_core: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cbam_pkg.sv
rtl/core/cbam_div.sv
rtl/core/container_block_address_map_core.sv
dv/tb_container_block_address_map_core.sv
